/* rtl/hbdts_pkg.sv */
// Package for the H-bridge drive and timed steering block.
// Holds field widths, action and mode codes, the interface structs and the
// percent-to-duty table builder. Depends on nothing.
package hbdts_pkg;

	localparam int DUTY_BITS_DEF = 10;
	localparam int DUTY_W        = DUTY_BITS_DEF;
	localparam int PCT_W         = 7;
	localparam int POS_W         = 7;
	localparam int PULSE_W       = 17;
	localparam int THR_W         = 8;
	localparam int TGT_W         = 8;
	localparam int DEADBAND_W    = 7;
	localparam int MSPU_W        = 10;
	localparam int CFG_DATA_W    = 10;
	localparam int CFG_INDEX_W   = 1;
	localparam int TAB_DEPTH     = 1 << PCT_W;
	localparam int PCT_SCALE     = 100;

	localparam logic [PCT_W-1:0]      PCT_FULL     = 7'd100;
	localparam logic [PCT_W-1:0]      STEER_PCT    = 7'd80;
	localparam logic [POS_W-1:0]      POS_CENTER   = 7'd50;
	localparam logic [POS_W-1:0]      POS_MAX      = 7'd100;
	localparam logic [PULSE_W-1:0]    PULSE_MIN    = 17'd20;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 7'd2;
	localparam logic [MSPU_W-1:0]     MSPU_RST     = 10'd10;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SET      = 2'd1,
		ACT_COAST    = 2'd2,
		ACT_RECENTER = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_COAST = 2'd0,
		MODE_FWD   = 2'd1,
		MODE_REV   = 2'd2,
		MODE_BRAKE = 2'd3
	} drive_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STEER_DEADBAND = 1'b0,
		CFG_MS_PER_UNIT    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic    fire;
		action_t action;
	} step_ctl_t;

	typedef struct packed {
		logic [DUTY_W-1:0]       fwd;
		logic [DUTY_W-1:0]       rev;
		logic signed [THR_W-1:0] thr;
		logic                    braking;
	} drive_res_t;

	typedef struct packed {
		logic [DUTY_W-1:0] right;
		logic [DUTY_W-1:0] left;
		logic [POS_W-1:0]  pos;
		logic              busy;
	} steer_res_t;

	typedef logic [15:0] duty_tab_t [0:TAB_DEPTH-1];

	function automatic duty_tab_t duty_table(input int unsigned duty_bits);
		duty_tab_t   tab;
		int unsigned full;
		full = (32'd1 << duty_bits) - 32'd1;
		for (int unsigned i = 0; i < TAB_DEPTH; i++) begin
			if (i == 0)
				tab[i] = 16'd0;
			else if (i >= PCT_SCALE)
				tab[i] = full[15:0];
			else
				tab[i] = 16'((i * full) / PCT_SCALE);
		end
		return tab;
	endfunction

endpackage

/* rtl/hbdts_drive.sv */
// Drive motor state: mode and saturated percent, plus the result fields
// derived from them after each item. Depends on hbdts_pkg.
module hbdts_drive (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hbdts_pkg::step_ctl_t                 ctl,
	input  logic signed [hbdts_pkg::THR_W-1:0]   throttle,
	output hbdts_pkg::drive_res_t                res
);

	localparam hbdts_pkg::duty_tab_t DUTY_TAB =
		hbdts_pkg::duty_table(hbdts_pkg::DUTY_BITS_DEF);

	hbdts_pkg::drive_mode_t            mode_q, mode_d;
	logic [hbdts_pkg::PCT_W-1:0]       pct_q, pct_d;
	logic                              neg;
	logic [hbdts_pkg::THR_W-1:0]       mag;
	logic [hbdts_pkg::PCT_W-1:0]       sat;
	logic [hbdts_pkg::DUTY_W-1:0]      duty;
	logic [hbdts_pkg::DUTY_W-1:0]      full;
	logic signed [hbdts_pkg::THR_W-1:0] pct_s;

	always_comb begin
		neg = throttle[hbdts_pkg::THR_W-1];
		mag = neg ? (~$unsigned(throttle) + 8'd1) : $unsigned(throttle);
		sat = (mag > {1'b0, hbdts_pkg::PCT_FULL}) ? hbdts_pkg::PCT_FULL
			: mag[hbdts_pkg::PCT_W-1:0];
	end

	always_comb begin
		mode_d = mode_q;
		pct_d  = pct_q;
		if (ctl.fire) begin
			unique case (ctl.action)
				hbdts_pkg::ACT_SET: begin
					if (sat == '0) begin
						mode_d = hbdts_pkg::MODE_BRAKE;
						pct_d  = '0;
					end else begin
						mode_d = neg ? hbdts_pkg::MODE_REV : hbdts_pkg::MODE_FWD;
						pct_d  = sat;
					end
				end
				hbdts_pkg::ACT_COAST: begin
					mode_d = hbdts_pkg::MODE_COAST;
					pct_d  = '0;
				end
				hbdts_pkg::ACT_TICK, hbdts_pkg::ACT_RECENTER: begin
				end
			endcase
		end
	end

	always_comb begin
		duty  = DUTY_TAB[pct_d][hbdts_pkg::DUTY_W-1:0];
		full  = DUTY_TAB[hbdts_pkg::PCT_FULL][hbdts_pkg::DUTY_W-1:0];
		pct_s = $signed({1'b0, pct_d});
		res   = '0;
		unique case (mode_d)
			hbdts_pkg::MODE_FWD: begin
				res.fwd = duty;
				res.thr = pct_s;
			end
			hbdts_pkg::MODE_REV: begin
				res.rev = duty;
				res.thr = -pct_s;
			end
			hbdts_pkg::MODE_BRAKE: begin
				res.fwd     = full;
				res.rev     = full;
				res.braking = 1'b1;
			end
			hbdts_pkg::MODE_COAST: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hbdts_pkg::MODE_COAST;
			pct_q  <= '0;
		end else begin
			mode_q <= mode_d;
			pct_q  <= pct_d;
		end
	end

endmodule

/* rtl/hbdts_steer.sv */
// Steering motor state: pending and active targets, position estimate and
// the pulse countdown, with the two configuration registers. Depends on hbdts_pkg.
module hbdts_steer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [hbdts_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hbdts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  hbdts_pkg::step_ctl_t                  ctl,
	input  logic [hbdts_pkg::TGT_W-1:0]           target,
	output hbdts_pkg::steer_res_t                 res
);

	localparam hbdts_pkg::duty_tab_t DUTY_TAB =
		hbdts_pkg::duty_table(hbdts_pkg::DUTY_BITS_DEF);
	localparam logic [hbdts_pkg::DUTY_W-1:0] STEER_DUTY =
		DUTY_TAB[hbdts_pkg::STEER_PCT][hbdts_pkg::DUTY_W-1:0];

	logic [hbdts_pkg::DEADBAND_W-1:0] deadband_q;
	logic [hbdts_pkg::MSPU_W-1:0]     mspu_q;
	logic [hbdts_pkg::POS_W-1:0]      pos_q, pos_d;
	logic [hbdts_pkg::POS_W-1:0]      pend_q, pend_d;
	logic                             pend_vld_q, pend_vld_d;
	logic [hbdts_pkg::POS_W-1:0]      act_q, act_d;
	logic [hbdts_pkg::PULSE_W-1:0]    pulse_q, pulse_d;
	logic                             dir_q, dir_d;

	logic [hbdts_pkg::PULSE_W-1:0]    pulse_dec;
	logic [hbdts_pkg::POS_W-1:0]      tgt_clamp;
	logic                             go_right;
	logic [hbdts_pkg::POS_W-1:0]      delta;
	logic [hbdts_pkg::PULSE_W-1:0]    len;
	logic [hbdts_pkg::PULSE_W-1:0]    len_sat;

	always_comb begin
		pulse_dec = pulse_q - 17'd1;
		tgt_clamp = (target > {1'b0, hbdts_pkg::POS_MAX}) ? hbdts_pkg::POS_MAX
			: target[hbdts_pkg::POS_W-1:0];
		go_right  = pend_q > pos_q;
		delta     = go_right ? (pend_q - pos_q) : (pos_q - pend_q);
		len       = hbdts_pkg::PULSE_W'(delta) * hbdts_pkg::PULSE_W'(mspu_q);
		len_sat   = (len < hbdts_pkg::PULSE_MIN) ? hbdts_pkg::PULSE_MIN : len;
	end

	always_comb begin
		pos_d      = pos_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		act_d      = act_q;
		pulse_d    = pulse_q;
		dir_d      = dir_q;
		if (ctl.fire) begin
			unique case (ctl.action)
				hbdts_pkg::ACT_TICK: begin
					if (pulse_q != '0) begin
						pulse_d = pulse_dec;
						if (pulse_dec == '0)
							pos_d = act_q;
					end else if (pend_vld_q) begin
						pend_vld_d = 1'b0;
						dir_d      = go_right;
						if (delta > deadband_q) begin
							act_d   = pend_q;
							pulse_d = len_sat;
						end
					end
				end
				hbdts_pkg::ACT_SET: begin
					pend_d     = tgt_clamp;
					pend_vld_d = 1'b1;
				end
				hbdts_pkg::ACT_RECENTER: begin
					pos_d = hbdts_pkg::POS_CENTER;
				end
				hbdts_pkg::ACT_COAST: begin
				end
			endcase
		end
	end

	always_comb begin
		res       = '0;
		res.pos   = pos_d;
		res.busy  = pulse_d != '0;
		res.right = (res.busy && dir_d) ? STEER_DUTY : '0;
		res.left  = (res.busy && !dir_d) ? STEER_DUTY : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= hbdts_pkg::DEADBAND_RST;
			mspu_q     <= hbdts_pkg::MSPU_RST;
		end else if (cfg_wr_en) begin
			unique case (hbdts_pkg::cfg_index_t'(cfg_index))
				hbdts_pkg::CFG_STEER_DEADBAND:
					deadband_q <= cfg_wdata[hbdts_pkg::DEADBAND_W-1:0];
				hbdts_pkg::CFG_MS_PER_UNIT:
					mspu_q     <= cfg_wdata[hbdts_pkg::MSPU_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= hbdts_pkg::POS_CENTER;
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
			act_q      <= hbdts_pkg::POS_CENTER;
			pulse_q    <= '0;
			dir_q      <= 1'b0;
		end else begin
			pos_q      <= pos_d;
			pend_q     <= pend_d;
			pend_vld_q <= pend_vld_d;
			act_q      <= act_d;
			pulse_q    <= pulse_d;
			dir_q      <= dir_d;
		end
	end

endmodule

/* rtl/hbridge_drive_and_timed_steer.sv */
// Top level of the H-bridge drive and timed steering block.
// Input register, drive and steer state units, result register.
// Depends on hbdts_pkg, hbdts_drive and hbdts_steer.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready   tuser: action; tdata: throttle, target
//   m_*       out        m_tvalid / m_tready   tdata: duties, position, throttle, flags
//   cfg_*     in         cfg_wr_en             cfg_index, cfg_wdata
//
// One item per cycle sustained while m_tready holds; an accepted item goes
// through the input register, then the result register. Each item is
// registered, then drive and steer state update in one pass as it moves into
// the result register, which also holds the result item. A stalled result
// holds the pipe; the input register takes one more item while the result
// waits, then the input stalls. Reset clears valids and loads the reset state.
module hbridge_drive_and_timed_steer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [1:0]                          s_tuser,  // action
	input  logic [15:0]                         s_tdata,  // drive_throttle, steer_target
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// drive_fwd_duty, drive_rev_duty, steer_right_duty, steer_left_duty,
	// steer_position, throttle_now, is_braking, steer_busy, zero fill
	output logic [63:0]                         m_tdata,
	input  logic                                cfg_wr_en,
	input  logic [hbdts_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [hbdts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic                                 valid_s1;
	hbdts_pkg::action_t                   action_s1;
	logic signed [hbdts_pkg::THR_W-1:0]   throttle_s1;
	logic [hbdts_pkg::TGT_W-1:0]          target_s1;
	logic                                 out_valid_s2;
	hbdts_pkg::drive_res_t                drive_s2;
	hbdts_pkg::steer_res_t                steer_s2;

	logic                                 adv;
	hbdts_pkg::step_ctl_t                 ctl;
	hbdts_pkg::drive_res_t                drive_res;
	hbdts_pkg::steer_res_t                steer_res;

	assign adv      = !out_valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign ctl      = '{fire: valid_s1 && adv, action: action_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1   <= hbdts_pkg::action_t'(s_tuser);
			throttle_s1 <= $signed(s_tdata[7:0]);
			target_s1   <= s_tdata[15:8];
		end
	end

	hbdts_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.throttle (throttle_s1),
		.res      (drive_res)
	);

	hbdts_steer u_steer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.target    (target_s1),
		.res       (steer_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (adv)
			out_valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			drive_s2 <= drive_res;
			steer_s2 <= steer_res;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {7'd0, steer_s2.busy, drive_s2.braking, drive_s2.thr, steer_s2.pos,
		steer_s2.left, steer_s2.right, drive_s2.rev, drive_s2.fwd};

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire |=> out_valid_s2)
		else $error("item left the input register without a result");

	a_zero_throttle_brakes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && action_s1 == hbdts_pkg::ACT_SET && throttle_s1 == '0
		|=> drive_s2.braking)
		else $error("zero throttle did not brake");

	a_coast_releases: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && action_s1 == hbdts_pkg::ACT_COAST
		|=> !drive_s2.braking && drive_s2.fwd == '0 && drive_s2.rev == '0 && drive_s2.thr == '0)
		else $error("coast left a drive input active");

	a_recenter_position: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && action_s1 == hbdts_pkg::ACT_RECENTER
		|=> steer_s2.pos == hbdts_pkg::POS_CENTER)
		else $error("recenter did not set the centre position");

endmodule

/* tb/sv/hbridge_drive_and_timed_steer_tb.sv */
// Testbench for hbridge_drive_and_timed_steer: drives random and directed items
// under random stalls and checks every result item against an in-bench predictor.
// Depends on hbdts_pkg and the block's RTL only.
module hbridge_drive_and_timed_steer_tb;
	import hbdts_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;

	// from the lowest bit up: fwd, rev, right, left, pos, thr, brake, busy, zero fill
	typedef struct packed {
		logic [6:0]              fill;
		logic                    busy;
		logic                    brake;
		logic signed [THR_W-1:0] thr;
		logic [POS_W-1:0]        pos;
		logic [DUTY_W-1:0]       left;
		logic [DUTY_W-1:0]       right;
		logic [DUTY_W-1:0]       rev;
		logic [DUTY_W-1:0]       fwd;
	} bridge_out_t;

	class bridge_predictor;
		logic [DEADBAND_W-1:0] deadband;
		logic [MSPU_W-1:0]     ms_unit;
		logic [POS_W-1:0]      pos;
		logic [POS_W-1:0]      queued_tgt;
		logic [POS_W-1:0]      pulse_tgt;
		bit                    queued;
		logic [PULSE_W-1:0]    remaining;
		bit                    turning_right;
		drive_mode_t           mode;
		int                    pct;
		bridge_out_t           pending_outputs[$];
		int                    failures;
		int                    seen;

		function new();
			deadband = DEADBAND_RST;
			ms_unit = MSPU_RST;
			pos = POS_CENTER;
			queued_tgt = '0;
			pulse_tgt = POS_CENTER;
			queued = 0;
			remaining = '0;
			turning_right = 0;
			mode = MODE_COAST;
			pct = 0;
			failures = 0;
			seen = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_STEER_DEADBAND)
				deadband = val[DEADBAND_W-1:0];
			else
				ms_unit = val[MSPU_W-1:0];
		endfunction

		function logic [DUTY_W-1:0] duty_of(int p);
			int full;
			full = (1 << DUTY_W) - 1;
			if (p == 0)
				return '0;
			if (p >= PCT_SCALE)
				return DUTY_W'(full);
			return DUTY_W'((p * full) / PCT_SCALE);
		endfunction

		function void tick();
			int delta;
			int len;
			if (remaining != 0) begin
				remaining--;
				if (remaining == 0)
					pos = pulse_tgt;
				return;
			end
			if (!queued)
				return;
			queued = 0;
			turning_right = queued_tgt > pos;
			delta = turning_right ? int'(queued_tgt) - int'(pos) : int'(pos) - int'(queued_tgt);
			if (delta <= int'(deadband))
				return;
			len = delta * int'(ms_unit);
			if (len < int'(PULSE_MIN))
				len = int'(PULSE_MIN);
			pulse_tgt = queued_tgt;
			remaining = PULSE_W'(len);
		endfunction

		function void apply_item(action_t act, logic [7:0] thr_raw, logic [7:0] tgt);
			int mag;
			bridge_out_t res;
			case (act)
				ACT_TICK: tick();
				ACT_SET: begin
					mag = thr_raw[7] ? 256 - int'(thr_raw) : int'(thr_raw);
					if (mag > PCT_SCALE)
						mag = PCT_SCALE;
					if (mag == 0)
						mode = MODE_BRAKE;
					else
						mode = thr_raw[7] ? MODE_REV : MODE_FWD;
					pct = mag;
					queued_tgt = (tgt > POS_MAX) ? POS_MAX : tgt[POS_W-1:0];
					queued = 1;
				end
				ACT_COAST: begin
					mode = MODE_COAST;
					pct = 0;
				end
				ACT_RECENTER: pos = POS_CENTER;
			endcase
			res = '0;
			case (mode)
				MODE_FWD: begin
					res.fwd = duty_of(pct);
					res.thr = THR_W'(pct);
				end
				MODE_REV: begin
					res.rev = duty_of(pct);
					res.thr = THR_W'(-pct);
				end
				MODE_BRAKE: begin
					res.fwd = duty_of(PCT_SCALE);
					res.rev = duty_of(PCT_SCALE);
					res.brake = 1'b1;
				end
				MODE_COAST: ;
			endcase
			if (remaining != 0) begin
				if (turning_right)
					res.right = duty_of(STEER_PCT);
				else
					res.left = duty_of(STEER_PCT);
				res.busy = 1'b1;
			end
			res.pos = pos;
			pending_outputs.push_back(res);
		endfunction

		function void check_output(logic [63:0] word);
			bridge_out_t got;
			bridge_out_t want;
			got = bridge_out_t'(word);
			seen++;
			if (pending_outputs.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result %0d with no item outstanding: %h", seen, word);
				return;
			end
			want = pending_outputs.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10) begin
					$display("result %0d exp: fwd %0d rev %0d right %0d left %0d pos %0d thr %0d brake %0b busy %0b fill %0h",
						seen, want.fwd, want.rev, want.right, want.left, want.pos, want.thr,
						want.brake, want.busy, want.fill);
					$display("result %0d got: fwd %0d rev %0d right %0d left %0d pos %0d thr %0d brake %0b busy %0b fill %0h",
						seen, got.fwd, got.rev, got.right, got.left, got.pos, got.thr,
						got.brake, got.busy, got.fill);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [1:0]             s_tuser;  // action
	logic [15:0]            s_tdata;  // drive_throttle, steer_target
	logic                   m_tvalid;
	logic                   m_tready;
	logic [63:0]            m_tdata;  // fwd, rev, right, left, pos, thr, brake, busy, fill
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	bridge_predictor pred;
	bit              idling_on;
	int              rx_hold;
	int              rx_stall;
	int              no_gap;
	int              quiet;

	hbridge_drive_and_timed_steer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pred.check_output(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: a long hold-off once run_random squeezes, else short random stalls while idling is on
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 5) == 0)
					rx_stall = $urandom_range(1, 6);
			end
		end
	end

	task automatic offer(input action_t act, input logic [7:0] thr, input logic [7:0] tgt);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {tgt, thr};
		do @(posedge clk); while (!s_tready);
		pred.apply_item(act, thr, tgt);
		if (no_gap > 0)
			no_gap--;
		else if (idling_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pred.write_reg(idx, val);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pred.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_throttle();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'($urandom);
			default: return 8'($urandom_range(0, 200) - 100);
		endcase
	endfunction

	function automatic logic [7:0] rand_target();
		case ($urandom_range(0, 7))
			0: return 8'($urandom);
			1: return 8'(pred.pos) + 8'($urandom_range(0, 8)) - 8'd4;
			default: return 8'($urandom_range(0, 100));
		endcase
	endfunction

	// mostly a set followed by a run of ticks, the rest single items of any action
	task automatic run_random(input int count, input bit squeeze);
		int  done;
		int  ticks;
		bit  pressed;
		done = 0;
		pressed = 0;
		while (done < count) begin
			if (squeeze && !pressed && done >= 60) begin
				rx_hold = $urandom_range(50, 80);
				no_gap = 60;
				pressed = 1;
			end
			if ($urandom_range(0, 9) < 6) begin
				offer(ACT_SET, rand_throttle(), rand_target());
				ticks = $urandom_range(1, 45);
				repeat (ticks) offer(ACT_TICK, 8'($urandom), 8'($urandom));
				done += ticks + 1;
			end else begin
				offer(action_t'($urandom_range(0, 3)), rand_throttle(), rand_target());
				done++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idling_on = 1;
		rx_hold = 0;
		rx_stall = 0;
		no_gap = 0;
		quiet = 0;
		pred = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_STEER_DEADBAND, 10'd3);
		write_reg(CFG_MS_PER_UNIT, 10'd1);
		offer(ACT_SET, 8'd0, 8'd50);
		offer(ACT_TICK, 8'd0, 8'd0);
		offer(ACT_SET, 8'd100, 8'd255);
		offer(ACT_TICK, 8'd0, 8'd0);
		offer(ACT_SET, 8'h9C, 8'd0);
		offer(ACT_RECENTER, 8'd0, 8'd0);
		offer(ACT_SET, 8'h7F, 8'd101);
		offer(ACT_SET, 8'h80, 8'd100);
		offer(ACT_SET, 8'd1, 8'd53);
		offer(ACT_SET, 8'hFF, 8'd54);
		offer(ACT_SET, 8'd101, 8'd3);
		offer(ACT_SET, 8'h9B, 8'd97);
		offer(ACT_SET, 8'd50, 8'd128);
		offer(ACT_SET, 8'd99, 8'd64);
		offer(ACT_COAST, 8'hFF, 8'hFF);
		offer(ACT_TICK, 8'hFF, 8'hFF);
		offer(ACT_TICK, 8'd0, 8'd0);
		offer(ACT_RECENTER, 8'd0, 8'd0);
		run_random(350, 1);

		drain();
		write_reg(CFG_STEER_DEADBAND, 10'd0);
		write_reg(CFG_MS_PER_UNIT, 10'd0);
		run_random(300, 0);

		drain();
		write_reg(CFG_STEER_DEADBAND, 10'd127);
		write_reg(CFG_MS_PER_UNIT, 10'd2);
		run_random(200, 0);

		drain();
		write_reg(CFG_STEER_DEADBAND, 10'd1);
		write_reg(CFG_MS_PER_UNIT, 10'd1023);
		run_random(200, 0);

		drain();
		write_reg(CFG_STEER_DEADBAND, 10'd2);
		write_reg(CFG_MS_PER_UNIT, 10'd10);
		run_random(300, 0);

		drain();
		write_reg(CFG_STEER_DEADBAND, 10'd5);
		write_reg(CFG_MS_PER_UNIT, 10'd3);
		idling_on = 0;
		run_random(300, 0);

		drain();
		repeat (10) @(posedge clk);
		if (pred.failures == 0 && pred.pending_outputs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
